### design/lrpe_pkg.sv
// Package with the shared types and constants of the LR table parse engine.
package lrpe_pkg;

  localparam int unsigned PayloadW     = 12;
  localparam int unsigned ResolveDepth = 4096;
  localparam int unsigned ChainMax     = 63;
  localparam logic [7:0]  EndMark      = 8'hff;

  typedef enum logic [2:0] {
    FUNC_TOKEN    = 3'd0,
    FUNC_DISPATCH = 3'd1,
    FUNC_ACTION   = 3'd2,
    FUNC_GOTO     = 3'd3,
    FUNC_RESOLVE  = 3'd4,
    FUNC_ACCEPT   = 3'd5,
    FUNC_PUSH     = 3'd6,
    FUNC_CLEAR    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    KIND_ACTION   = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_REJECT   = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_CHAIN    = 3'd4
  } kind_e;

  typedef enum logic {
    CFG_SHIFT_LIMIT = 1'b0,
    CFG_END_TOKEN   = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_DISP,
    ST_ACT,
    ST_BASE,
    ST_GOTO,
    ST_WB
  } step_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  token;
    logic [7:0]  row;
    logic [11:0] column;
    logic [15:0] table_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] payload;
    logic        last;
  } out_t;

  typedef struct packed {
    logic start;
    logic chain_max;
    logic empty;
    logic full;
    logic disp_end;
    logic acc_ok;
    logic pop_bad;
    logic consumed;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic  idle;
    logic  rd_top;
    logic  rd_disp;
    logic  rd_act;
    logic  rd_base;
    logic  rd_goto;
    logic  fin;
    kind_e fin_kind;
    logic  wb;
  } ctrl_t;

endpackage

### design/lrpe_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
interface lrpe_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/lrpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lrpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

### design/lrpe_fsm.sv
// Step sequencer of the parse engine: one action step walks the table reads in order.
module lrpe_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrpe_pkg::status_t st_i,
  output lrpe_pkg::ctrl_t   ct_o
);
  lrpe_pkg::step_e state_q, state_d;
  logic stop;

  assign stop = st_i.chain_max || st_i.empty || st_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrpe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrpe_pkg::ST_IDLE: begin
        if (st_i.start) state_d = lrpe_pkg::ST_TOP;
      end
      lrpe_pkg::ST_TOP: begin
        if (!stop) state_d = lrpe_pkg::ST_DISP;
        else if (st_i.out_free) state_d = lrpe_pkg::ST_IDLE;
      end
      lrpe_pkg::ST_DISP: state_d = lrpe_pkg::ST_ACT;
      lrpe_pkg::ST_ACT: begin
        if (!st_i.disp_end) state_d = lrpe_pkg::ST_BASE;
        else if (st_i.out_free) state_d = lrpe_pkg::ST_IDLE;
      end
      lrpe_pkg::ST_BASE: begin
        if (!st_i.pop_bad) state_d = lrpe_pkg::ST_GOTO;
        else if (st_i.out_free) state_d = lrpe_pkg::ST_IDLE;
      end
      lrpe_pkg::ST_GOTO: state_d = lrpe_pkg::ST_WB;
      lrpe_pkg::ST_WB: begin
        if (st_i.out_free) begin
          state_d = st_i.consumed ? lrpe_pkg::ST_IDLE : lrpe_pkg::ST_TOP;
        end
      end
      default: state_d = lrpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ct_o = '0;
    ct_o.fin_kind = lrpe_pkg::KIND_REJECT;
    unique case (state_q)
      lrpe_pkg::ST_IDLE: ct_o.idle = 1'b1;
      lrpe_pkg::ST_TOP: begin
        if (stop) begin
          ct_o.fin = st_i.out_free;
          priority if (st_i.chain_max) ct_o.fin_kind = lrpe_pkg::KIND_CHAIN;
          else if (st_i.empty) ct_o.fin_kind = lrpe_pkg::KIND_REJECT;
          else ct_o.fin_kind = lrpe_pkg::KIND_OVERFLOW;
        end else begin
          ct_o.rd_top = 1'b1;
        end
      end
      lrpe_pkg::ST_DISP: ct_o.rd_disp = 1'b1;
      lrpe_pkg::ST_ACT: begin
        if (st_i.disp_end) begin
          ct_o.fin = st_i.out_free;
          ct_o.fin_kind = st_i.acc_ok ? lrpe_pkg::KIND_ACCEPT : lrpe_pkg::KIND_REJECT;
        end else begin
          ct_o.rd_act = 1'b1;
        end
      end
      lrpe_pkg::ST_BASE: begin
        if (st_i.pop_bad) ct_o.fin = st_i.out_free;
        else ct_o.rd_base = 1'b1;
      end
      lrpe_pkg::ST_GOTO: ct_o.rd_goto = 1'b1;
      lrpe_pkg::ST_WB: ct_o.wb = st_i.out_free;
      default: ct_o.idle = 1'b0;
    endcase
  end
endmodule

### design/lr_table_parse_engine_top.sv
// Top level of the LR table parse engine: tables, parse stack and result register.
// Load items and clear items are taken while idle; the next item can be taken in the following cycle.
// A token item runs action steps through the states stack, dispatch, action, base, goto and write.
// A stop result is registered from the stack, action or base state, an action result from the write state.
// Reset empties the stack and clears the halted flag and both registers; tables stay undefined.
module lr_table_parse_engine_top #(
  parameter int unsigned STATES        = 256,
  parameter int unsigned TOKENS        = 64,
  parameter int unsigned DISPATCH_COLS = 16,
  parameter int unsigned GOTO_COLS     = 64,
  parameter int unsigned STACK_DEPTH   = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lrpe_stream_if.sink   in_i,
  lrpe_stream_if.source out_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [11:0]   cfg_data_i
);
  localparam int unsigned SW  = $clog2(STATES);
  localparam int unsigned LW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned DAW = $clog2(STATES * TOKENS);
  localparam int unsigned AAW = $clog2(STATES * DISPATCH_COLS);
  localparam int unsigned GAW = $clog2(STATES * GOTO_COLS);
  localparam int unsigned RAW = $clog2(lrpe_pkg::ResolveDepth);

  lrpe_pkg::status_t st;
  lrpe_pkg::ctrl_t   ct;
  lrpe_pkg::in_t     item;

  logic [LW-1:0]  level_q, level_d, top, base_l, idx;
  logic           halted_q, halted_d;
  logic [11:0]    limit_q;
  logic [5:0]     end_q, tok_q, cnt_q;
  logic           dok_q, gok_q;
  logic           out_valid_q;
  lrpe_pkg::out_t out_q;

  logic [15:0] stk_rd, act_rd, goto_rd;
  logic [7:0]  disp_rd;
  logic [5:0]  res_rd;
  logic        acc_rd;
  logic [3:0]  pop;
  logic [11:0] payload;
  logic        in_fire, row_ok, push_ok;
  logic        stk_we;
  logic [SAW-1:0] stk_wa, stk_ra;
  logic [15:0] stk_wd;

  assign item    = in_i.data;
  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = ct.idle;
  assign row_ok  = 32'(item.row) < STATES;

  assign top     = level_q - LW'(1);
  assign pop     = act_rd[15:12];
  assign payload = act_rd[11:0];
  assign base_l  = LW'(32'(top) - 32'(pop));
  assign idx     = base_l + LW'(payload != '0);
  assign push_ok = 32'(level_q) < STACK_DEPTH;

  always_comb begin
    st.start     = in_fire && (lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_TOKEN) && !halted_q;
    st.chain_max = 32'(cnt_q) >= lrpe_pkg::ChainMax;
    st.empty     = level_q == '0;
    st.full      = !push_ok;
    st.disp_end  = !dok_q || disp_rd == lrpe_pkg::EndMark || 32'(disp_rd) >= DISPATCH_COLS;
    st.acc_ok    = tok_q == end_q && 32'(stk_rd) < STATES && acc_rd;
    st.pop_bad   = 32'(pop) > 32'(top);
    st.consumed  = payload <= limit_q;
    st.out_free  = !out_valid_q || out_o.ready;
  end

  lrpe_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .ct_o   (ct)
  );

  lrpe_ram #(.Width(8), .Depth(STATES * TOKENS)) u_disp (
    .clk_i   (clk_i),
    .we_i    (in_fire && lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_DISPATCH && row_ok
              && 32'(item.token) < TOKENS),
    .waddr_i (DAW'(DAW'(item.row) * DAW'(TOKENS) + DAW'(item.token))),
    .wdata_i (item.table_data[7:0]),
    .re_i    (ct.rd_disp),
    .raddr_i (DAW'(DAW'(stk_rd) * DAW'(TOKENS) + DAW'(tok_q))),
    .rdata_o (disp_rd)
  );

  lrpe_ram #(.Width(16), .Depth(STATES * DISPATCH_COLS)) u_act (
    .clk_i   (clk_i),
    .we_i    (in_fire && lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_ACTION && row_ok
              && 32'(item.column) < DISPATCH_COLS),
    .waddr_i (AAW'(AAW'(item.row) * AAW'(DISPATCH_COLS) + AAW'(item.column))),
    .wdata_i (item.table_data),
    .re_i    (ct.rd_act),
    .raddr_i (AAW'(AAW'(stk_rd) * AAW'(DISPATCH_COLS) + AAW'(disp_rd))),
    .rdata_o (act_rd)
  );

  lrpe_ram #(.Width(16), .Depth(STATES * GOTO_COLS)) u_goto (
    .clk_i   (clk_i),
    .we_i    (in_fire && lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_GOTO && row_ok
              && 32'(item.column) < GOTO_COLS),
    .waddr_i (GAW'(GAW'(item.row) * GAW'(GOTO_COLS) + GAW'(item.column))),
    .wdata_i (item.table_data),
    .re_i    (ct.rd_goto),
    .raddr_i (GAW'(GAW'(stk_rd) * GAW'(GOTO_COLS) + GAW'(res_rd))),
    .rdata_o (goto_rd)
  );

  lrpe_ram #(.Width(6), .Depth(lrpe_pkg::ResolveDepth)) u_res (
    .clk_i   (clk_i),
    .we_i    (in_fire && lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_RESOLVE),
    .waddr_i (RAW'(item.column)),
    .wdata_i (item.table_data[5:0]),
    .re_i    (ct.rd_base),
    .raddr_i (RAW'(payload)),
    .rdata_o (res_rd)
  );

  lrpe_ram #(.Width(1), .Depth(STATES)) u_acc (
    .clk_i   (clk_i),
    .we_i    (in_fire && lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_ACCEPT && row_ok),
    .waddr_i (SW'(item.row)),
    .wdata_i (item.table_data[0]),
    .re_i    (ct.rd_disp),
    .raddr_i (SW'(stk_rd)),
    .rdata_o (acc_rd)
  );

  always_comb begin
    stk_we = 1'b0;
    stk_wa = level_q[SAW-1:0];
    stk_wd = item.table_data;
    if (ct.wb) begin
      stk_we = 1'b1;
      stk_wa = idx[SAW-1:0];
      stk_wd = gok_q ? goto_rd : '0;
    end else if (in_fire && lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_PUSH && push_ok) begin
      stk_we = 1'b1;
    end
  end

  assign stk_ra = ct.rd_base ? base_l[SAW-1:0] : top[SAW-1:0];

  lrpe_ram #(.Width(16), .Depth(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_wa),
    .wdata_i (stk_wd),
    .re_i    (ct.rd_top || ct.rd_base),
    .raddr_i (stk_ra),
    .rdata_o (stk_rd)
  );

  always_comb begin
    level_d  = level_q;
    halted_d = halted_q;
    if (ct.wb) begin
      level_d = idx + LW'(1);
    end else if (ct.fin) begin
      halted_d = 1'b1;
      if (ct.fin_kind == lrpe_pkg::KIND_ACCEPT) begin
        level_d = (level_q >= LW'(2)) ? level_q - LW'(2) : '0;
      end
    end else if (in_fire) begin
      if (lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_PUSH && push_ok) begin
        level_d = level_q + LW'(1);
      end else if (lrpe_pkg::func_e'(item.func) == lrpe_pkg::FUNC_CLEAR) begin
        level_d  = '0;
        halted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      halted_q    <= 1'b0;
      limit_q     <= '0;
      end_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      level_q  <= level_d;
      halted_q <= halted_d;
      if (cfg_we_i) begin
        unique case (lrpe_pkg::cfg_e'(cfg_idx_i))
          lrpe_pkg::CFG_SHIFT_LIMIT: limit_q <= cfg_data_i;
          lrpe_pkg::CFG_END_TOKEN:   end_q   <= cfg_data_i[5:0];
          default:                   limit_q <= limit_q;
        endcase
      end
      if (st.start) cnt_q <= '0;
      else if (ct.wb) cnt_q <= cnt_q + 6'd1;
      if (ct.fin || ct.wb) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st.start) tok_q <= item.token;
    if (ct.rd_disp) dok_q <= 32'(stk_rd) < STATES && 32'(tok_q) < TOKENS;
    if (ct.rd_goto) gok_q <= 32'(stk_rd) < STATES && 32'(res_rd) < GOTO_COLS;
    if (ct.wb) begin
      out_q.kind    <= lrpe_pkg::KIND_ACTION;
      out_q.payload <= payload;
      out_q.last    <= st.consumed;
    end else if (ct.fin) begin
      out_q.kind    <= ct.fin_kind;
      out_q.payload <= '0;
      out_q.last    <= 1'b1;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule

### design/lrpe_chk.sv
// Port-level checker of the parse engine and its bind to the top level.
module lrpe_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input lrpe_pkg::out_t out_data_i
);
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.kind <= lrpe_pkg::KIND_CHAIN)
    else $error("Result kind out of range.");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind != lrpe_pkg::KIND_ACTION |->
      out_data_i.last && out_data_i.payload == '0)
    else $error("Final result without last flag or with a payload.");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last |-> !in_ready_i)
    else $error("Input taken while a token is still running.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("Stalled result transaction changed.");
endmodule

bind lr_table_parse_engine_top lrpe_chk u_lrpe_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
